[hw/rtl/smsd_pkg.sv]
// Shared constants, command/status structs and controller state type for the
// sample statistics block. No dependencies.
`default_nettype none

package smsd_pkg;

  // Sample format and run bound
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int MAX_SAMPLES   = 65535;

  // Port field widths
  localparam int IN_DATA_W   = 16;
  localparam int OUT_CNT_W   = 16;
  localparam int OUT_MM_W    = 16;
  localparam int MEAN_W      = 24;
  localparam int SD_W        = 24;
  localparam int OUT_DATA_W  = OUT_CNT_W + 2 * OUT_MM_W + MEAN_W + SD_W;
  localparam int OUT_USER_W  = 2;

  // Accumulator widths
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int MAG_W = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + CNT_W;

  // Finish arithmetic widths
  localparam int PA_W    = CNT_W + SQ_W;
  localparam int PB_W    = 2 * SUM_W;
  localparam int DIFF_W  = (PA_W > PB_W) ? PA_W : PB_W;
  localparam int NUM_W   = DIFF_W + 2 * FRACTION_BITS;
  localparam int DIV_W   = 2 * CNT_W;
  localparam int SQREM_W = SD_W + 2;
  localparam int STEP_W  = $clog2(NUM_W);

  // Mean saturation bounds
  localparam logic [MEAN_W-1:0] MEAN_POS_SAT = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_NEG_SAT = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL,
    ST_DIV_MEAN,
    ST_MEAN_FIX,
    ST_DIV_VAR,
    ST_SQ_PREP,
    ST_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic out_ld;
    logic mul_ld;
    logic div_step;
    logic mean_ld;
    logic sq_prep;
    logic sq_step;
    logic sq_last;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_lt2;
    logic var_neg;
    logic sd_sat;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/smsd_ctrl.sv]
// Controller: sequences accumulate, multiply, divide and square-root phases
// and owns the stream handshakes. Depends on smsd_pkg.
`default_nettype none

module smsd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output logic                 in_tready,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output smsd_pkg::cmd_t       cmd,
  input  wire smsd_pkg::sts_t  sts
);

  smsd_pkg::state_t state_r, state_nxt;
  logic [smsd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic div_last, sq_last, out_free;

  assign div_last = (step_r == smsd_pkg::STEP_W'(smsd_pkg::NUM_W - 1));
  assign sq_last  = (step_r == smsd_pkg::STEP_W'(smsd_pkg::SD_W - 1));
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smsd_pkg::ST_ACCUM: begin
        if (in_tvalid && in_tlast) state_nxt = smsd_pkg::ST_MUL;
      end
      smsd_pkg::ST_MUL: begin
        state_nxt = sts.cnt_zero ? smsd_pkg::ST_DONE : smsd_pkg::ST_DIV_MEAN;
      end
      smsd_pkg::ST_DIV_MEAN: begin
        if (div_last) state_nxt = smsd_pkg::ST_MEAN_FIX;
      end
      smsd_pkg::ST_MEAN_FIX: begin
        if (sts.cnt_lt2 || sts.var_neg) state_nxt = smsd_pkg::ST_DONE;
        else state_nxt = smsd_pkg::ST_DIV_VAR;
      end
      smsd_pkg::ST_DIV_VAR: begin
        if (div_last) state_nxt = smsd_pkg::ST_SQ_PREP;
      end
      smsd_pkg::ST_SQ_PREP: begin
        state_nxt = sts.sd_sat ? smsd_pkg::ST_DONE : smsd_pkg::ST_SQRT;
      end
      smsd_pkg::ST_SQRT: begin
        if (sq_last) state_nxt = smsd_pkg::ST_DONE;
      end
      smsd_pkg::ST_DONE: begin
        if (out_free) state_nxt = smsd_pkg::ST_ACCUM;
      end
      default: state_nxt = smsd_pkg::ST_ACCUM;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    step_nxt  = '0;
    case (state_r)
      smsd_pkg::ST_ACCUM: begin
        in_tready  = 1'b1;
        cmd.acc_en = in_tvalid;
      end
      smsd_pkg::ST_MUL: begin
        cmd.mul_ld = 1'b1;
      end
      smsd_pkg::ST_DIV_MEAN, smsd_pkg::ST_DIV_VAR: begin
        cmd.div_step = 1'b1;
        step_nxt     = div_last ? '0 : step_r + smsd_pkg::STEP_W'(1);
      end
      smsd_pkg::ST_MEAN_FIX: begin
        cmd.mean_ld = 1'b1;
      end
      smsd_pkg::ST_SQ_PREP: begin
        cmd.sq_prep = 1'b1;
      end
      smsd_pkg::ST_SQRT: begin
        cmd.sq_step = 1'b1;
        cmd.sq_last = sq_last;
        step_nxt    = sq_last ? '0 : step_r + smsd_pkg::STEP_W'(1);
      end
      smsd_pkg::ST_DONE: begin
        cmd.out_ld = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Hold a result until the transaction completes
  always_comb begin
    if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smsd_pkg::ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/smsd_dp.sv]
// Datapath: running accumulators, finish multipliers, shared restoring
// divider, bit-serial square root and output register. Depends on smsd_pkg.
`default_nettype none

module smsd_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire smsd_pkg::cmd_t                     cmd,
  output smsd_pkg::sts_t                          sts,
  input  wire logic [smsd_pkg::IN_DATA_W-1:0]     in_sample,
  input  wire logic                               in_flag,
  output logic [smsd_pkg::OUT_DATA_W-1:0]         out_data,
  output logic [smsd_pkg::OUT_USER_W-1:0]         out_user
);

  // Accumulators
  logic [smsd_pkg::CNT_W-1:0]              cnt_r;
  logic signed [smsd_pkg::SUM_W-1:0]       sum_r;
  logic [smsd_pkg::SQ_W-1:0]               sq_r;
  logic signed [smsd_pkg::SAMPLE_BITS-1:0] min_r, max_r;
  logic                                    ovf_r;

  // Finish registers
  logic [smsd_pkg::PA_W-1:0]    prod_a_r;
  logic [smsd_pkg::PB_W-1:0]    prod_b_r;
  logic [smsd_pkg::DIV_W-1:0]   dvar_r, div_r, rem_r, rem_nxt;
  logic [smsd_pkg::NUM_W-1:0]   quo_r;
  logic                         neg_r;
  logic [smsd_pkg::MEAN_W-1:0]  mean_r, mean_nxt;
  logic [smsd_pkg::SD_W-1:0]    sd_r, root_r, root_nxt;
  logic [smsd_pkg::SQREM_W-1:0] sqrem_r, sqrem_nxt;
  logic [smsd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [smsd_pkg::OUT_USER_W-1:0] out_user_r;

  logic signed [smsd_pkg::SAMPLE_BITS-1:0] x;
  logic [smsd_pkg::MAG_W-1:0]       x_mag;
  logic [2*smsd_pkg::MAG_W-1:0]     x_sq;
  logic [smsd_pkg::SUM_W-1:0]       s1_mag;
  logic [smsd_pkg::DIFF_W-1:0]      diff;
  logic [smsd_pkg::NUM_W-1:0]       var_num;
  logic [smsd_pkg::DIV_W:0]         div_t;
  logic                             div_ge;
  logic [smsd_pkg::MEAN_W-1:0]      q_lo;
  logic [smsd_pkg::SQREM_W+1:0]     sq_t, sq_trial;
  logic                             sq_ge;

  // Sample decode
  assign x     = in_sample[smsd_pkg::SAMPLE_BITS-1:0];
  assign x_mag = x[smsd_pkg::SAMPLE_BITS-1] ? smsd_pkg::MAG_W'(-x) : smsd_pkg::MAG_W'(x);
  assign x_sq  = x_mag * x_mag;

  // Update run accumulators; clear when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_ld) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      min_r <= '0;
      max_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc_en && in_flag) begin
      if (cnt_r == smsd_pkg::CNT_W'(smsd_pkg::MAX_SAMPLES)) begin
        ovf_r <= 1'b1;
      end else begin
        if (cnt_r == '0) begin
          min_r <= x;
          max_r <= x;
        end else if (x < min_r) begin
          min_r <= x;
        end else if (x > max_r) begin
          max_r <= x;
        end
        cnt_r <= cnt_r + smsd_pkg::CNT_W'(1);
        sum_r <= sum_r + smsd_pkg::SUM_W'(x);
        sq_r  <= sq_r + smsd_pkg::SQ_W'(x_sq);
      end
    end
  end

  // Products and operands for the finish
  assign s1_mag  = sum_r[smsd_pkg::SUM_W-1] ? smsd_pkg::SUM_W'(-sum_r)
                                            : smsd_pkg::SUM_W'(sum_r);
  assign diff    = smsd_pkg::DIFF_W'(prod_a_r) - smsd_pkg::DIFF_W'(prod_b_r);
  assign var_num = smsd_pkg::NUM_W'(diff) << (2 * smsd_pkg::FRACTION_BITS);

  // Restoring divider: one quotient bit per step
  assign div_t   = {rem_r, quo_r[smsd_pkg::NUM_W-1]};
  assign div_ge  = (div_t >= {1'b0, div_r});
  assign rem_nxt = div_ge ? smsd_pkg::DIV_W'(div_t - {1'b0, div_r})
                          : smsd_pkg::DIV_W'(div_t);

  // Signed mean from the unsigned quotient, saturated
  assign q_lo = quo_r[smsd_pkg::MEAN_W-1:0];
  always_comb begin
    if (neg_r) begin
      if (quo_r > smsd_pkg::NUM_W'(smsd_pkg::MEAN_NEG_SAT)) mean_nxt = smsd_pkg::MEAN_NEG_SAT;
      else mean_nxt = -q_lo;
    end else begin
      if (quo_r > smsd_pkg::NUM_W'(smsd_pkg::MEAN_POS_SAT)) mean_nxt = smsd_pkg::MEAN_POS_SAT;
      else mean_nxt = q_lo;
    end
  end

  // Square root: two radicand bits per step, one root bit out
  assign sq_t      = {sqrem_r, quo_r[smsd_pkg::NUM_W-1 -: 2]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = (sq_t >= sq_trial);
  assign sqrem_nxt = sq_ge ? smsd_pkg::SQREM_W'(sq_t - sq_trial) : smsd_pkg::SQREM_W'(sq_t);
  assign root_nxt  = {root_r[smsd_pkg::SD_W-2:0], sq_ge};

  // Multiplier stage
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_a_r <= cnt_r * sq_r;
      prod_b_r <= s1_mag * s1_mag;
      dvar_r   <= cnt_r * (cnt_r - smsd_pkg::CNT_W'(1));
      neg_r    <= sum_r[smsd_pkg::SUM_W-1];
    end
  end

  // Divider and root registers
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      quo_r <= smsd_pkg::NUM_W'(s1_mag) << smsd_pkg::FRACTION_BITS;
      rem_r <= '0;
      div_r <= smsd_pkg::DIV_W'(cnt_r);
    end else if (cmd.mean_ld) begin
      quo_r <= var_num;
      rem_r <= '0;
      div_r <= dvar_r;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[smsd_pkg::NUM_W-2:0], div_ge};
      rem_r <= rem_nxt;
    end else if (cmd.sq_prep) begin
      quo_r <= quo_r << (smsd_pkg::NUM_W - 2 * smsd_pkg::SD_W);
    end else if (cmd.sq_step) begin
      quo_r <= quo_r << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_prep) begin
      sqrem_r <= '0;
      root_r  <= '0;
    end else if (cmd.sq_step) begin
      sqrem_r <= sqrem_nxt;
      root_r  <= root_nxt;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      mean_r <= '0;
      sd_r   <= '0;
    end else begin
      if (cmd.mean_ld) mean_r <= mean_nxt;
      if (cmd.sq_prep && sts.sd_sat) sd_r <= '1;
      else if (cmd.sq_step && cmd.sq_last) sd_r <= root_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {sd_r, mean_r, smsd_pkg::OUT_MM_W'(max_r),
                     smsd_pkg::OUT_MM_W'(min_r), smsd_pkg::OUT_CNT_W'(cnt_r)};
      out_user_r <= {ovf_r, (cnt_r != '0)};
    end
  end

  assign out_data = out_data_r;
  assign out_user = out_user_r;

  // Status to the controller
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_lt2  = (cnt_r < smsd_pkg::CNT_W'(2));
  assign sts.var_neg  = (prod_a_r < prod_b_r);
  assign sts.sd_sat   = |quo_r[smsd_pkg::NUM_W-1:2*smsd_pkg::SD_W];

endmodule

`default_nettype wire

[hw/rtl/sample_mean_stddev_min_max_top.sv]
// Top level of the sample statistics block: count, min, max, mean and sample
// standard deviation per run. Depends on smsd_pkg, smsd_ctrl, smsd_dp.
//
//   channel  direction  payload
//   in_      slave      tdata[15:0] sample, tuser valid flag, tlast end of run
//   out_     master     tdata[95:0] statistics, tuser[1:0] stats_valid/overflow
//
// Run items are taken one per cycle. After the item with tlast, in_tready
// stays low for the finish, which skips the divider when no sample is valid
// and the variance pass when only one is. The finish time is set by the shared
// restoring divider (run for the mean and again for the variance) and the
// 24-step bit-serial square root. Reset is synchronous, active low, and clears
// the accumulators, the controller and out_tvalid. A result waits in the output
// register while the next run streams in; a second finish holds until it drains.
`default_nettype none

module sample_mean_stddev_min_max_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [smsd_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] sample
  input  wire logic                               in_tuser,   // [0] sample_valid
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] valid_count, [31:16] minimum, [47:32] maximum,
  // [71:48] mean_value, [95:72] std_deviation
  output logic [smsd_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [smsd_pkg::OUT_USER_W-1:0]         out_tuser   // [0] stats_valid, [1] overflow
);

  smsd_pkg::cmd_t cmd;
  smsd_pkg::sts_t sts;

  smsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  smsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (in_tdata),
    .in_flag   (in_tuser),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/smsd_chk.sv]
// Port-level checker for the sample statistics block, bound to the top level.
// Depends on smsd_pkg.
`default_nettype none

module smsd_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tlast,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [smsd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic [smsd_pkg::OUT_USER_W-1:0]    out_tuser
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input closes after the last transaction of a run
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after end of run");

  // Empty run reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("empty run with nonzero fields");

  // Minimum never exceeds maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> $signed(out_tdata[31:16]) <= $signed(out_tdata[47:32]))
    else $error("minimum above maximum");

  // A single sample has zero spread
  a_single_sd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] == 16'd1 |-> out_tdata[95:72] == 24'd0)
    else $error("nonzero deviation for one sample");

endmodule

bind sample_mean_stddev_min_max_top smsd_chk u_smsd_chk (.*);

`default_nettype wire
